// ----- rtl/core/tdpf_pkg.sv -----
package tdpf_pkg;

    // Fixed width of the value fields on both channels.
    localparam int FIELD_W = 16;

    // Default for the width of the tested value.
    localparam int VALUE_WIDTH_DEF = 16;

    // Smallest divisor that trial division tries.
    localparam int FIRST_DIVISOR = 2;

    // One input item.
    typedef struct packed {
        logic [FIELD_W-1:0] candidate;
        logic               range_first;
        logic               range_last;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [FIELD_W-1:0] tested_value;
        logic               is_prime;
        logic [FIELD_W-1:0] list_index;
        logic               last;
    } t_out_item;

    // Status of the shared remainder unit.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_stat;

endpackage

// ----- rtl/core/tdpf_rem_unit.sv -----
module tdpf_rem_unit #(
    parameter int W = tdpf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_dividend,
    input  logic [W-1:0]         i_divisor,
    output tdpf_pkg::t_div_stat  o_stat
);
    import tdpf_pkg::*;

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_bits;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_divisor;

    logic [W:0]       trial;
    logic [W-1:0]     n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_bits[W-1]};
        if (trial >= {1'b0, r_divisor}) begin
            n_rem = W'(trial - {1'b0, r_divisor});
        end else begin
            n_rem = trial[W-1:0];
        end
    end

    // Control of the bit-serial sweep, one dividend bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt     <= CNT_W'(W - 1);
            r_bits    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_bits <= {r_bits[W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

// ----- rtl/core/trial_division_prime_filter_core.sv -----
// Candidates below 4 need no remainder test; for the others each divisor tried costs a pass
// through the shared bit-serial remainder unit plus a bound check in the sequencer, so the
// worst case for 16 bits is a prime near 65535. One candidate is in work at a time; the
// next is taken while the result waits in the output register.
// Reset (synchronous, active low) clears the sequencer, output valid and prime count.
module trial_division_prime_filter_core #(
    parameter int VALUE_WIDTH = tdpf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tdpf_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tdpf_pkg::t_out_item o_out
);
    import tdpf_pkg::*;

    localparam int CW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int SW = CW + 2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cand, n_cand;
    logic               r_last, n_last;
    logic [CW-1:0]      r_div, n_div;
    logic [SW-1:0]      r_sq, n_sq;
    logic               r_prime, n_prime;
    logic [FIELD_W-1:0] r_count, n_count;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic      in_acc;
    logic      out_free;
    logic      div_start;
    t_div_stat div_stat;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Shared remainder unit.
    tdpf_rem_unit #(
        .W (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_stat     (div_stat)
    );

    // Sequencer: bound check, remainder test, next divisor, result hand-off.
    always_comb begin
        n_state     = r_state;
        n_cand      = r_cand;
        n_last      = r_last;
        n_div       = r_div;
        n_sq        = r_sq;
        n_prime     = r_prime;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        div_start   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cand  = i_in.candidate[CW-1:0];
                    n_last  = i_in.range_last;
                    n_div   = CW'(FIRST_DIVISOR);
                    n_sq    = SW'(FIRST_DIVISOR * FIRST_DIVISOR);
                    if (i_in.range_first) begin
                        n_count = '0;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_cand < CW'(FIRST_DIVISOR)) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else if (r_sq > SW'(r_cand)) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (div_stat.rem_zero) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        // (d + 1)^2 = d^2 + 2d + 1
                        n_div   = r_div + 1'b1;
                        n_sq    = r_sq + SW'({r_div, 1'b1});
                        n_state = S_CHECK;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.tested_value = FIELD_W'(r_cand);
                    n_out.is_prime     = r_prime;
                    n_out.list_index   = r_prime ? r_count : '0;
                    n_out.last         = r_last;
                    n_out_valid        = 1'b1;
                    if (r_prime) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_last  <= n_last;
        r_div   <= n_div;
        r_sq    <= n_sq;
        r_prime <= n_prime;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_prime_at_least_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_prime |-> o_out.tested_value >= FIELD_W'(FIRST_DIVISOR))
        else $error("prime result below the first divisor");

    a_nonprime_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.is_prime |-> o_out.list_index == '0)
        else $error("non-prime result carries a list index");

    a_divisor_below_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div < r_cand)
        else $error("divisor reached the candidate");

    a_divisor_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> r_div >= CW'(FIRST_DIVISOR))
        else $error("divisor below the first divisor");

    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> r_state == S_DIV && !div_start)
        else $error("remainder unit restarted while busy");
`endif

endmodule

// ----- test/tb_trial_division_prime_filter_core.sv -----
`timescale 1ns / 1ps

module tb_trial_division_prime_filter_core;
    import tdpf_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 80;
    localparam int TAIL_ITEMS    = 20;
    localparam int HOLD_AFTER    = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2000000;

    // One item waiting to be offered, optionally only once the block has drained.
    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_stim;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    t_stim       candidates_to_send[$];
    t_out_item   verdicts_due[$];
    logic [15:0] primes_in_range;
    int          items_taken;
    int          verdicts_checked;
    int          primes_seen;
    int          ranges_opened;
    int          fail_count;
    int          cycle_count;
    int          send_gap;
    int          stall_left;
    int          hold_left;
    bit          hold_done;
    bit          tail_phase;

    trial_division_prime_filter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    // Free-running clock.
    always #CLK_HALF i_clk = ~i_clk;

    // Trial division up to the square root gives the same verdict as the full search.
    function automatic bit prime_by_trial(input logic [15:0] n);
        int unsigned d;
        if (n < FIRST_DIVISOR) begin
            return 1'b0;
        end
        for (d = FIRST_DIVISOR; d * d <= n; d++) begin
            if (n % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Work out the verdict for one accepted item and queue it.
    task automatic predict_verdict(input t_in_item it);
        t_out_item v;
        if (it.range_first) begin
            primes_in_range = '0;
            ranges_opened++;
        end
        v.tested_value = it.candidate;
        v.is_prime     = prime_by_trial(it.candidate);
        v.list_index   = v.is_prime ? primes_in_range : '0;
        v.last         = it.range_last;
        if (v.is_prime) begin
            primes_in_range = primes_in_range + 16'd1;
            primes_seen++;
        end
        verdicts_due.push_back(v);
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch, %s", $time, what);
        fail_count++;
    endtask

    task automatic queue_candidate(input int value, input bit first, input bit last,
                                   input bit drain);
        t_stim s;
        s.item.candidate   = value[15:0];
        s.item.range_first = first;
        s.item.range_last  = last;
        s.drain_first      = drain;
        candidates_to_send.push_back(s);
    endtask

    // Mostly small candidates keep the run short; a few span the full range.
    function automatic int pick_candidate();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535);
            1:       return $urandom_range(0, 3);
            2:       return $urandom_range(1024, 4095);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // Idling is switched off in one stretch out of three.
    function automatic bit quiet_stretch();
        return (cycle_count / 128) % 3 == 0;
    endfunction

    // Sender: offer items from the queue, with random gaps and drain pauses.
    always @(posedge i_clk) begin : drive_candidates
        bit took;
        took = in_valid && in_ready;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (took) begin
                predict_verdict(in_item);
                items_taken++;
            end
            if (candidates_to_send.size() <= TAIL_ITEMS) begin
                tail_phase = 1'b1;
            end
            if (!in_valid || took) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (candidates_to_send.size() != 0 &&
                             !(candidates_to_send[0].drain_first && verdicts_due.size() != 0)) begin
                    in_item  <= candidates_to_send[0].item;
                    in_valid <= 1'b1;
                    void'(candidates_to_send.pop_front());
                    if (!tail_phase && !quiet_stretch() && $urandom_range(0, 3) == 0) begin
                        send_gap = $urandom_range(1, 11);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result and drive ready with stalls and one long hold.
    always @(posedge i_clk) begin : check_verdicts
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                verdicts_checked++;
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("result for %0d with nothing expected",
                                              out_item.tested_value));
                end else begin
                    want = verdicts_due.pop_front();
                    if (out_item.tested_value !== want.tested_value) begin
                        report_mismatch($sformatf("tested_value %0d, expected %0d",
                                                  out_item.tested_value, want.tested_value));
                    end
                    if (out_item.is_prime !== want.is_prime) begin
                        report_mismatch($sformatf("is_prime %b for %0d, expected %b",
                                                  out_item.is_prime, want.tested_value,
                                                  want.is_prime));
                    end
                    if (out_item.list_index !== want.list_index) begin
                        report_mismatch($sformatf("list_index %0d for %0d, expected %0d",
                                                  out_item.list_index, want.tested_value,
                                                  want.list_index));
                    end
                    if (out_item.last !== want.last) begin
                        report_mismatch($sformatf("last %b for %0d, expected %b",
                                                  out_item.last, want.tested_value, want.last));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!hold_done && items_taken >= HOLD_AFTER) begin
                // Long hold-off so the block backs up and stalls its input.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!tail_phase && !quiet_stretch() && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 10);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles.", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int  range_len;
        int  queued;
        bit  well_formed;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_valid         = 1'b0;
        in_item          = '0;
        out_ready        = 1'b0;
        primes_in_range  = '0;
        items_taken      = 0;
        verdicts_checked = 0;
        primes_seen      = 0;
        ranges_opened    = 0;
        fail_count       = 0;
        send_gap         = 0;
        stall_left       = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        tail_phase       = 1'b0;

        // Directed: primes before any range start, then the edge values.
        queue_candidate(2, 1'b0, 1'b0, 1'b0);
        queue_candidate(3, 1'b0, 1'b0, 1'b0);
        queue_candidate(0, 1'b1, 1'b0, 1'b0);
        queue_candidate(1, 1'b0, 1'b0, 1'b0);
        queue_candidate(2, 1'b0, 1'b0, 1'b0);
        queue_candidate(4, 1'b0, 1'b0, 1'b0);
        queue_candidate(5, 1'b0, 1'b0, 1'b0);
        queue_candidate(9, 1'b0, 1'b0, 1'b0);
        queue_candidate(25, 1'b0, 1'b0, 1'b0);
        queue_candidate(49, 1'b0, 1'b0, 1'b0);
        queue_candidate(65535, 1'b0, 1'b0, 1'b0);
        queue_candidate(65521, 1'b0, 1'b0, 1'b0);
        queue_candidate(16'h8000, 1'b0, 1'b0, 1'b0);
        queue_candidate(16'h5555, 1'b0, 1'b0, 1'b0);
        queue_candidate(16'hAAAA, 1'b0, 1'b0, 1'b0);
        queue_candidate(63001, 1'b0, 1'b1, 1'b0);
        // A last flag alone does not clear the count.
        queue_candidate(13, 1'b0, 1'b1, 1'b0);
        // Single-candidate ranges with both flags set.
        queue_candidate(17, 1'b1, 1'b1, 1'b0);
        queue_candidate(65521, 1'b1, 1'b1, 1'b0);
        queue_candidate(4, 1'b1, 1'b1, 1'b0);
        queue_candidate(255, 1'b0, 1'b0, 1'b0);
        queue_candidate(16'h7FFF, 1'b0, 1'b0, 1'b0);
        queue_candidate(97, 1'b0, 1'b1, 1'b0);

        // Random ranges, mostly well formed; one item waits for the block to drain.
        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            range_len   = $urandom_range(1, 8);
            well_formed = $urandom_range(0, 4) != 0;
            for (int i = 0; i < range_len; i++) begin
                queue_candidate(pick_candidate(),
                                well_formed ? (i == 0) : bit'($urandom_range(0, 1)),
                                well_formed ? (i == range_len - 1) : bit'($urandom_range(0, 1)),
                                queued == RANDOM_ITEMS / 2);
                queued++;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (candidates_to_send.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (verdicts_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Tested %0d candidates across %0d range starts, %0d of them prime,",
                 verdicts_checked, ranges_opened, primes_seen);
        $display("with sender gaps, receiver stalls, one long hold-off and one drain pause.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tdpf_pkg.sv
rtl/core/tdpf_rem_unit.sv
rtl/core/trial_division_prime_filter_core.sv
test/tb_trial_division_prime_filter_core.sv
